@@ hdl/quaternion_to_euler_angles_unit_defines.svh @@
// assertion macros for the quaternion to euler angles unit
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH

// a condition implies a consequence on the same edge
`define Q2E_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// a condition implies a consequence on the next edge
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/q2e_pkg.sv @@
`default_nettype none
package q2e_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CW           = 35;
    localparam int ZW           = 26;
    localparam int SQW          = 57;
    localparam int SQ_STEPS     = 29;
    localparam int SQ_PER_STG   = 2;
    localparam int SQ_STAGES    = (SQ_STEPS + SQ_PER_STG - 1) / SQ_PER_STG;
    localparam int LAT          = 3 + SQ_STAGES + 2 + CORDIC_STEPS + 1;
    localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 * 65536);
    localparam logic signed [15:0] ROLLYAW_MAX = 16'sd23040;
    localparam logic signed [14:0] PITCH_MAX   = 15'sd11520;

    typedef logic signed [CW-1:0] t_cval;
    typedef logic signed [ZW-1:0] t_ang;

    typedef struct packed {
        t_cval x;
        t_cval y;
        t_ang  z;
        logic  zero;
    } t_cstate;

    function automatic t_ang atan_entry(input int i);
        case (i)
            0: atan_entry = ZW'(2949120);
            1: atan_entry = ZW'(1740967);
            2: atan_entry = ZW'(919879);
            3: atan_entry = ZW'(466945);
            4: atan_entry = ZW'(234379);
            5: atan_entry = ZW'(117304);
            6: atan_entry = ZW'(58666);
            7: atan_entry = ZW'(29335);
            8: atan_entry = ZW'(14668);
            9: atan_entry = ZW'(7334);
            10: atan_entry = ZW'(3667);
            11: atan_entry = ZW'(1833);
            12: atan_entry = ZW'(917);
            13: atan_entry = ZW'(458);
            14: atan_entry = ZW'(229);
            15: atan_entry = ZW'(115);
            16: atan_entry = ZW'(57);
            17: atan_entry = ZW'(29);
            18: atan_entry = ZW'(14);
            19: atan_entry = ZW'(7);
            20: atan_entry = ZW'(4);
            21: atan_entry = ZW'(2);
            22: atan_entry = ZW'(1);
            default: atan_entry = '0;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ hdl/q2e_cordic.sv @@
`default_nettype none
module q2e_cordic (
    input  wire logic            i_clk,
    input  wire q2e_pkg::t_cval  i_y,
    input  wire q2e_pkg::t_cval  i_x,
    output q2e_pkg::t_ang        o_z,
    output logic                 o_zero
);
    import q2e_pkg::*;

    t_cstate r_st [0:CORDIC_STEPS];
    t_cstate n_pre;

    always_comb begin
        n_pre.zero = (i_x == '0) && (i_y == '0);
        n_pre.x    = i_x;
        n_pre.y    = i_y;
        n_pre.z    = '0;
        if (i_x < 0) begin
            n_pre.z = (i_y >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
            n_pre.x = -i_x;
            n_pre.y = -i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_pre;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        t_cval xs, ys;
        assign xs = r_st[g].x >>> g;
        assign ys = r_st[g].y >>> g;
        always_ff @(posedge i_clk) begin
            r_st[g+1].zero <= r_st[g].zero;
            if (r_st[g].y > 0) begin
                r_st[g+1].x <= r_st[g].x + ys;
                r_st[g+1].y <= r_st[g].y - xs;
                r_st[g+1].z <= r_st[g].z + atan_entry(g);
            end else begin
                r_st[g+1].x <= r_st[g].x - ys;
                r_st[g+1].y <= r_st[g].y + xs;
                r_st[g+1].z <= r_st[g].z - atan_entry(g);
            end
        end
    end

    assign o_z    = r_st[CORDIC_STEPS].z;
    assign o_zero = r_st[CORDIC_STEPS].zero;
endmodule
`default_nettype wire

@@ hdl/q2e_isqrt.sv @@
`default_nettype none
module q2e_isqrt (
    input  wire logic                       i_clk,
    input  wire logic [q2e_pkg::SQW-1:0]    i_v,
    output logic [28:0]                     o_root
);
    import q2e_pkg::*;

    logic [SQW-1:0] r_rem [0:SQ_STAGES];
    logic [SQW-1:0] r_res [0:SQ_STAGES];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_v;
        r_res[0] <= '0;
    end

    // restoring digit-by-digit root, two result bits per stage (one in the last)
    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stg
        logic [SQW-1:0] n_rem, n_res;
        always_comb begin
            logic [SQW-1:0] bit_v;
            bit_v = '0;
            n_rem = r_rem[g];
            n_res = r_res[g];
            for (int k = 0; k < SQ_PER_STG; k++) begin
                if (g * SQ_PER_STG + k < SQ_STEPS) begin
                    bit_v = SQW'(1) << (2 * (SQ_STEPS - 1 - (g * SQ_PER_STG + k)));
                    if (n_rem >= n_res + bit_v) begin
                        n_rem = n_rem - (n_res + bit_v);
                        n_res = (n_res >> 1) + bit_v;
                    end else begin
                        n_res = n_res >> 1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= n_rem;
            r_res[g+1] <= n_res;
        end
    end

    assign o_root = r_res[SQ_STAGES][28:0];
endmodule
`default_nettype wire

@@ hdl/quaternion_to_euler_angles_unit.sv @@
// One quaternion request is taken per clock whenever start is high (busy is always
// low); its euler angles appear with o_done after passing all of the pipeline's
// LAT = 3 + 15 + 2 + 16 + 1 = 37 register stages: products, sums and the pitch square,
// the input register and 15 stages of the square root for pitch, the input register and
// 16 stages of the cordic pipelines, and the output register. The output cannot be
// stalled, so a result must be taken when shown.
`default_nettype none
`include "quaternion_to_euler_angles_unit_defines.svh"
module quaternion_to_euler_angles_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic                    o_done,
    output logic signed [14:0]      o_pitch_deg,
    output logic signed [15:0]      o_yaw_deg,
    output logic signed [15:0]      o_roll_deg,
    output logic                    o_pitch_clamped
);
    import q2e_pkg::*;

    localparam int PW  = 33;
    localparam int DLY = SQ_STAGES + 2;

    logic [LAT-1:0] r_vld;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_cval r_ry, r_rx, r_yy2, r_yx, r_s;
    logic [57:0] r_ssq;
    t_cval r_d_ry [0:DLY-1];
    t_cval r_d_rx [0:DLY-1];
    t_cval r_d_yy [0:DLY-1];
    t_cval r_d_yx [0:DLY-1];
    t_cval r_d_s  [0:DLY-1];
    logic [28:0] w_root;
    t_ang w_zr, w_zp, w_zy;
    logic w_nr, w_np, w_ny;
    logic [1:0] r_cl [0:CORDIC_STEPS];
    logic signed [14:0] r_pitch;
    logic signed [15:0] r_yaw, r_roll;
    logic r_clamp;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        r_wx <= PW'(i_quat_w) * PW'(i_quat_x);
        r_yz <= PW'(i_quat_y) * PW'(i_quat_z);
        r_xx <= PW'(i_quat_x) * PW'(i_quat_x);
        r_yy <= PW'(i_quat_y) * PW'(i_quat_y);
        r_wy <= PW'(i_quat_w) * PW'(i_quat_y);
        r_zx <= PW'(i_quat_z) * PW'(i_quat_x);
        r_wz <= PW'(i_quat_w) * PW'(i_quat_z);
        r_xy <= PW'(i_quat_x) * PW'(i_quat_y);
        r_zz <= PW'(i_quat_z) * PW'(i_quat_z);
    end

    // stage 2: sums
    always_ff @(posedge i_clk) begin
        r_ry  <= CW'(2) * (CW'(r_wx) + CW'(r_yz));
        r_rx  <= (CW'(1) <<< 28) - CW'(2) * (CW'(r_xx) + CW'(r_yy));
        r_yy2 <= CW'(2) * (CW'(r_wz) + CW'(r_xy));
        r_yx  <= (CW'(1) <<< 28) - CW'(2) * (CW'(r_yy) + CW'(r_zz));
        r_s   <= CW'(2) * (CW'(r_wy) - CW'(r_zx));
    end

    // stage 3: square of the pitch term, only its low 29 bits matter when not clamped
    logic [SQW-1:0] w_rad;
    logic signed [28:0] w_sl;
    assign w_sl = r_s[28:0];
    always_ff @(posedge i_clk) begin
        r_ssq <= 58'(w_sl) * 58'(w_sl);
    end
    assign w_rad = SQW'((58'd1 << 56) - r_ssq);

    always_ff @(posedge i_clk) begin
        r_d_ry[0] <= r_ry;
        r_d_rx[0] <= r_rx;
        r_d_yy[0] <= r_yy2;
        r_d_yx[0] <= r_yx;
        r_d_s[0]  <= r_s;
        for (int k = 1; k < DLY; k++) begin
            r_d_ry[k] <= r_d_ry[k-1];
            r_d_rx[k] <= r_d_rx[k-1];
            r_d_yy[k] <= r_d_yy[k-1];
            r_d_yx[k] <= r_d_yx[k-1];
            r_d_s[k]  <= r_d_s[k-1];
        end
    end

    q2e_isqrt u_sqrt (.i_clk(i_clk), .i_v(w_rad), .o_root(w_root));

    q2e_cordic u_roll (.i_clk(i_clk), .i_y(r_d_ry[DLY-1]), .i_x(r_d_rx[DLY-1]),
        .o_z(w_zr), .o_zero(w_nr));
    q2e_cordic u_pitch (.i_clk(i_clk), .i_y(r_d_s[DLY-1]), .i_x(CW'(w_root)),
        .o_z(w_zp), .o_zero(w_np));
    q2e_cordic u_yaw (.i_clk(i_clk), .i_y(r_d_yy[DLY-1]), .i_x(r_d_yx[DLY-1]),
        .o_z(w_zy), .o_zero(w_ny));

    // clamp code: bit1 clamped, bit0 sign negative
    t_cval w_sd;
    assign w_sd = r_d_s[DLY-1];
    always_ff @(posedge i_clk) begin
        r_cl[0] <= {(w_sd >= (CW'(1) <<< 28)) || (w_sd <= -(CW'(1) <<< 28)), w_sd[CW-1]};
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            r_cl[k] <= r_cl[k-1];
        end
    end

    function automatic logic signed [17:0] to_deg(input t_ang z, input logic zero);
        t_ang t;
        t = z + ZW'(256);
        to_deg = zero ? 18'sd0 : 18'(t >>> 9);
    endfunction

    logic signed [17:0] w_dr, w_dp, w_dy;
    assign w_dr = to_deg(w_zr, w_nr);
    assign w_dp = to_deg(w_zp, w_np);
    assign w_dy = to_deg(w_zy, w_ny);

    always_ff @(posedge i_clk) begin
        r_roll <= (w_dr > 18'(ROLLYAW_MAX)) ? ROLLYAW_MAX :
                  (w_dr < -18'(ROLLYAW_MAX)) ? -ROLLYAW_MAX : w_dr[15:0];
        r_yaw  <= (w_dy > 18'(ROLLYAW_MAX)) ? ROLLYAW_MAX :
                  (w_dy < -18'(ROLLYAW_MAX)) ? -ROLLYAW_MAX : w_dy[15:0];
        r_clamp <= r_cl[CORDIC_STEPS][1];
        if (r_cl[CORDIC_STEPS][1]) begin
            r_pitch <= r_cl[CORDIC_STEPS][0] ? -PITCH_MAX : PITCH_MAX;
        end else begin
            r_pitch <= (w_dp > 18'(PITCH_MAX)) ? PITCH_MAX :
                       (w_dp < -18'(PITCH_MAX)) ? -PITCH_MAX : w_dp[14:0];
        end
    end

    assign o_done          = r_vld[LAT-1];
    assign o_pitch_deg     = r_pitch;
    assign o_yaw_deg       = r_yaw;
    assign o_roll_deg      = r_roll;
    assign o_pitch_clamped = r_clamp;

    `Q2E_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy, "busy raised")
    `Q2E_ASSERT_IMPL(a_pitch_range, i_clk, i_rst_n, o_done,
        (o_pitch_deg <= PITCH_MAX) && (o_pitch_deg >= -PITCH_MAX), "pitch range")
    `Q2E_ASSERT_IMPL(a_clamp_val, i_clk, i_rst_n, o_done && o_pitch_clamped,
        (o_pitch_deg == PITCH_MAX) || (o_pitch_deg == -PITCH_MAX), "clamp value")
    `Q2E_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_vld[LAT-2], o_done, "done lost")
endmodule
`default_nettype wire
